@@ design/bcc_pkg.sv @@
`timescale 1ns / 1ps

package bcc_pkg;

    // Coordinate and weight formats
    localparam int COORD_W = 16;
    localparam int WFRAC   = 16;
    localparam int WEIGHT_W = 32;
    localparam int QBITS   = WEIGHT_W;

    // Intermediate widths, all exact
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int DPROD_W = 2 * CROSS_W;
    localparam int DOT_W   = DPROD_W + 2;
    localparam int NUM_W   = DOT_W + WFRAC;
    localparam int TOP_W   = NUM_W - QBITS;

    // Pipeline depth
    localparam int GEOM_LAT  = 6;
    localparam int DIV_LAT   = QBITS + 2;
    localparam int TOTAL_LAT = GEOM_LAT + DIV_LAT;

    // Stream widths
    localparam int IN_FIELDS = 12;
    localparam int IN_W      = IN_FIELDS * COORD_W;
    localparam int OUT_W     = 3 * WEIGHT_W;

    localparam logic [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [CROSS_W-1:0] t_cross;
    typedef logic signed [DPROD_W-1:0] t_dprod;
    typedef logic signed [DOT_W-1:0]   t_dot;
    typedef logic [DOT_W-1:0]          t_mag;
    typedef logic [WEIGHT_W-1:0]       t_weight;

endpackage

@@ design/triangle_barycentric_coordinates.sv @@
`timescale 1ns / 1ps

// Barycentric weights of a point against a 3D triangle. Each item carries the
// point and three vertices in signed Q8.8; the result holds alpha, beta and
// gamma in signed Q16.16, truncated toward zero and saturated, plus a
// degenerate flag (weights zero) when the triangle normal has zero length.
// One item is accepted every cycle unless the pipeline holds; it runs six stages of
// vector arithmetic, then a restoring divider that resolves one quotient bit
// per stage (32 stages) framed by an overflow-check and a saturation stage.
// The whole pipeline holds while a result waits on m_axis_tready.
module triangle_barycentric_coordinates (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
    input  logic [bcc_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // weight_alpha, weight_beta, weight_gamma
    output logic [bcc_pkg::OUT_W-1:0] m_axis_tdata,
    // degenerate
    output logic                      m_axis_tuser
);

    localparam int CW = bcc_pkg::COORD_W;

    logic            en;
    bcc_pkg::t_coord p [3];
    bcc_pkg::t_coord a [3];
    bcc_pkg::t_coord b [3];
    bcc_pkg::t_coord c [3];
    bcc_pkg::t_mag   mag [3];
    logic            neg [3];
    bcc_pkg::t_mag   den;
    logic            degen;
    bcc_pkg::t_weight w [3];

    logic [bcc_pkg::TOTAL_LAT-1:0] r_vld;
    logic [bcc_pkg::DIV_LAT-1:0]   r_degen;

    assign en            = !r_vld[bcc_pkg::TOTAL_LAT-1] || m_axis_tready;
    assign s_axis_tready = en;

    // unpack coordinates
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p[i] = s_axis_tdata[(i)*CW +: CW];
            a[i] = s_axis_tdata[(3+i)*CW +: CW];
            b[i] = s_axis_tdata[(6+i)*CW +: CW];
            c[i] = s_axis_tdata[(9+i)*CW +: CW];
        end
    end

    bcc_geom u_geom (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_p     (p),
        .i_a     (a),
        .i_b     (b),
        .i_c     (c),
        .o_mag   (mag),
        .o_neg   (neg),
        .o_den   (den),
        .o_degen (degen)
    );

    for (genvar j = 0; j < 3; j++) begin : g_div
        bcc_div u_div (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_mag    (mag[j]),
            .i_neg    (neg[j]),
            .i_den    (den),
            .o_weight (w[j])
        );
    end

    // valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[bcc_pkg::TOTAL_LAT-2:0], s_axis_tvalid};
        end
    end

    // degenerate flag follows the divider latency
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_degen <= {r_degen[bcc_pkg::DIV_LAT-2:0], degen};
        end
    end

    assign m_axis_tvalid = r_vld[bcc_pkg::TOTAL_LAT-1];
    assign m_axis_tuser  = r_degen[bcc_pkg::DIV_LAT-1];
    assign m_axis_tdata  = m_axis_tuser ? '0 : {w[2], w[1], w[0]};

endmodule

@@ design/bcc_geom.sv @@
`timescale 1ns / 1ps

// Edge vectors, normals and dot products: six register stages
module bcc_geom (
    input  logic            i_clk,
    input  logic            i_en,
    input  bcc_pkg::t_coord i_p [3],
    input  bcc_pkg::t_coord i_a [3],
    input  bcc_pkg::t_coord i_b [3],
    input  bcc_pkg::t_coord i_c [3],
    output bcc_pkg::t_mag   o_mag [3],
    output logic            o_neg [3],
    output bcc_pkg::t_mag   o_den,
    output logic            o_degen
);

    // cross operand pairs: n = ab x ac, na = bc x bp, nb = ca x cp, nc = ab x ap
    bcc_pkg::t_diff  r_u  [4][3];
    bcc_pkg::t_diff  r_v  [4][3];
    bcc_pkg::t_prod  r_pr [4][6];
    bcc_pkg::t_cross r_x  [4][3];
    bcc_pkg::t_dprod r_dp [4][3];
    bcc_pkg::t_dot   r_dot [4];
    bcc_pkg::t_mag   r_mag [3];
    logic            r_neg [3];
    bcc_pkg::t_mag   r_den;
    logic            r_degen;

    // stage 1: differences
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_u[0][i] <= bcc_pkg::DIFF_W'(i_b[i]) - bcc_pkg::DIFF_W'(i_a[i]);
                r_v[0][i] <= bcc_pkg::DIFF_W'(i_c[i]) - bcc_pkg::DIFF_W'(i_a[i]);
                r_u[1][i] <= bcc_pkg::DIFF_W'(i_c[i]) - bcc_pkg::DIFF_W'(i_b[i]);
                r_v[1][i] <= bcc_pkg::DIFF_W'(i_p[i]) - bcc_pkg::DIFF_W'(i_b[i]);
                r_u[2][i] <= bcc_pkg::DIFF_W'(i_a[i]) - bcc_pkg::DIFF_W'(i_c[i]);
                r_v[2][i] <= bcc_pkg::DIFF_W'(i_p[i]) - bcc_pkg::DIFF_W'(i_c[i]);
                r_u[3][i] <= bcc_pkg::DIFF_W'(i_b[i]) - bcc_pkg::DIFF_W'(i_a[i]);
                r_v[3][i] <= bcc_pkg::DIFF_W'(i_p[i]) - bcc_pkg::DIFF_W'(i_a[i]);
            end
        end
    end

    // stage 2: cross product partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                r_pr[j][0] <= bcc_pkg::PROD_W'(r_u[j][1]) * bcc_pkg::PROD_W'(r_v[j][2]);
                r_pr[j][1] <= bcc_pkg::PROD_W'(r_u[j][2]) * bcc_pkg::PROD_W'(r_v[j][1]);
                r_pr[j][2] <= bcc_pkg::PROD_W'(r_u[j][2]) * bcc_pkg::PROD_W'(r_v[j][0]);
                r_pr[j][3] <= bcc_pkg::PROD_W'(r_u[j][0]) * bcc_pkg::PROD_W'(r_v[j][2]);
                r_pr[j][4] <= bcc_pkg::PROD_W'(r_u[j][0]) * bcc_pkg::PROD_W'(r_v[j][1]);
                r_pr[j][5] <= bcc_pkg::PROD_W'(r_u[j][1]) * bcc_pkg::PROD_W'(r_v[j][0]);
            end
        end
    end

    // stage 3: cross components
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_x[j][i] <= bcc_pkg::CROSS_W'(r_pr[j][2*i])
                               - bcc_pkg::CROSS_W'(r_pr[j][2*i+1]);
                end
            end
        end
    end

    // stage 4: dot products against n (index 0 gives |n|^2)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_dp[j][i] <= bcc_pkg::DPROD_W'(r_x[j][i])
                                * bcc_pkg::DPROD_W'(r_x[0][i]);
                end
            end
        end
    end

    // stage 5: dot sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                r_dot[j] <= bcc_pkg::DOT_W'(r_dp[j][0]) + bcc_pkg::DOT_W'(r_dp[j][1])
                          + bcc_pkg::DOT_W'(r_dp[j][2]);
            end
        end
    end

    // stage 6: sign and magnitude, degenerate check
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_neg[j] <= r_dot[j+1][bcc_pkg::DOT_W-1];
                r_mag[j] <= r_dot[j+1][bcc_pkg::DOT_W-1] ? bcc_pkg::t_mag'(-r_dot[j+1])
                                                         : bcc_pkg::t_mag'(r_dot[j+1]);
            end
            r_den   <= bcc_pkg::t_mag'(r_dot[0]);
            r_degen <= (r_dot[0] == '0);
        end
    end

    assign o_mag   = r_mag;
    assign o_neg   = r_neg;
    assign o_den   = r_den;
    assign o_degen = r_degen;

endmodule

@@ design/bcc_div.sv @@
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, with saturation
module bcc_div (
    input  logic             i_clk,
    input  logic             i_en,
    input  bcc_pkg::t_mag    i_mag,
    input  logic             i_neg,
    input  bcc_pkg::t_mag    i_den,
    output bcc_pkg::t_weight o_weight
);

    localparam int QB = bcc_pkg::QBITS;
    localparam int DW = bcc_pkg::DOT_W;

    logic [bcc_pkg::NUM_W-1:0] n_num;
    logic                      n_ovf;

    logic [DW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_low [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [DW-1:0] r_den [QB+1];
    logic          r_neg [QB+1];
    logic          r_ovf [QB+1];
    bcc_pkg::t_weight r_w;

    // quotient overflows when the high part of the numerator reaches den
    assign n_num = bcc_pkg::NUM_W'(i_mag) << bcc_pkg::WFRAC;
    assign n_ovf = DW'(n_num[bcc_pkg::NUM_W-1:QB]) >= i_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(n_num[bcc_pkg::NUM_W-1:QB]);
            r_low[0] <= n_num[QB-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_ovf[0] <= n_ovf;
        end
    end

    // one step per stage
    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [DW:0] t;
        logic [DW:0] d;
        logic        ge;
        assign t  = {r_rem[k], r_low[k][QB-1]};
        assign d  = t - {1'b0, r_den[k]};
        assign ge = t >= {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? d[DW-1:0] : t[DW-1:0];
                r_low[k+1] <= r_low[k] << 1;
                r_q[k+1]   <= {r_q[k][QB-2:0], ge};
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    // sign and saturation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ovf[QB] || r_q[QB][QB-1]) begin
                r_w <= r_neg[QB] ? bcc_pkg::W_MIN : bcc_pkg::W_MAX;
            end else begin
                r_w <= r_neg[QB] ? bcc_pkg::t_weight'(-r_q[QB]) : bcc_pkg::t_weight'(r_q[QB]);
            end
        end
    end

    assign o_weight = r_w;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int N_RANDOM    = 900;
    localparam int QUIET_TAIL  = 100;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [bcc_pkg::WEIGHT_W-1:0] gamma;
        logic [bcc_pkg::WEIGHT_W-1:0] beta;
        logic [bcc_pkg::WEIGHT_W-1:0] alpha;
        logic                         degen;
    } t_weights;

    // One directed row: coordinates p, a, b, c (x, y, z each), optional typed result
    typedef struct {
        logic [bcc_pkg::IN_W-1:0] coords;
        bit                       typed;
        t_weights                 res;
    } t_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [bcc_pkg::IN_W-1:0]  s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [bcc_pkg::OUT_W-1:0] m_axis_tdata;
    logic                      m_axis_tuser;

    triangle_barycentric_coordinates u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_weights    pending_weights[$];
    t_row        rows[$];
    int          mismatches;
    int          n_results;
    int          n_degen;
    int          n_sat;
    int          cycles;
    int          n_sent;
    bit          quiet;

    // Truncated quotient in Q16.16 with saturation
    function automatic logic [bcc_pkg::WEIGHT_W-1:0] quotient(
        input logic signed [127:0] num,
        input logic [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = num[127] ? -num : num;
        q = (mag << bcc_pkg::WFRAC) / den;
        if (num[127]) begin
            if (q >= 128'h8000_0000) return bcc_pkg::W_MIN;
            return bcc_pkg::WEIGHT_W'(-q);
        end
        if (q > 128'h7FFF_FFFF) return bcc_pkg::W_MAX;
        return q[bcc_pkg::WEIGHT_W-1:0];
    endfunction

    function automatic logic signed [127:0] dot(input longint u[3], input longint v[3]);
        logic signed [127:0] s;
        logic signed [127:0] x;
        logic signed [127:0] y;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            x = u[k];
            y = v[k];
            s = s + x * y;
        end
        return s;
    endfunction

    function automatic void cross3(output longint o[3], input longint u[3],
                                   input longint v[3]);
        o[0] = u[1] * v[2] - u[2] * v[1];
        o[1] = u[2] * v[0] - u[0] * v[2];
        o[2] = u[0] * v[1] - u[1] * v[0];
    endfunction

    function automatic t_weights barycentric(input logic [bcc_pkg::IN_W-1:0] d);
        longint p[3], a[3], b[3], c[3];
        longint ab[3], ac[3], bc[3], ca[3], ap[3], bp[3], cp[3];
        longint n[3], na[3], nb[3], nc[3];
        logic signed [127:0] den;
        t_weights r;
        for (int k = 0; k < 3; k++) begin
            p[k] = longint'($signed(d[16*k +: 16]));
            a[k] = longint'($signed(d[16*(3+k) +: 16]));
            b[k] = longint'($signed(d[16*(6+k) +: 16]));
            c[k] = longint'($signed(d[16*(9+k) +: 16]));
        end
        for (int k = 0; k < 3; k++) begin
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            bc[k] = c[k] - b[k];
            ca[k] = a[k] - c[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
        end
        cross3(n, ab, ac);
        cross3(na, bc, bp);
        cross3(nb, ca, cp);
        cross3(nc, ab, ap);
        den = dot(n, n);
        r = '0;
        if (den == 0) begin
            r.degen = 1'b1;
            return r;
        end
        r.alpha = quotient(dot(na, n), den);
        r.beta  = quotient(dot(nb, n), den);
        r.gamma = quotient(dot(nc, n), den);
        return r;
    endfunction

    function automatic logic [bcc_pkg::IN_W-1:0] pack(input int v[12]);
        logic [bcc_pkg::IN_W-1:0] d;
        for (int k = 0; k < 12; k++) d[16*k +: 16] = 16'(v[k]);
        return d;
    endfunction

    function automatic void add_row(input int v[12], input bit typed, input t_weights res);
        t_row r;
        r.coords = pack(v);
        r.typed = typed;
        r.res = res;
        rows.push_back(r);
    endfunction

    // Random item: modest triangles for kinds 0-3, full range otherwise, some collinear
    function automatic logic [bcc_pkg::IN_W-1:0] random_item();
        int v[12];
        int kind;
        int span;
        kind = $urandom_range(0, 9);
        span = (kind < 4) ? 2048 : 32767;
        for (int k = 0; k < 12; k++) begin
            if (kind >= 7) v[k] = int'($signed(16'($urandom())));
            else v[k] = $urandom_range(0, 2 * span) - span;
        end
        case (kind)
            5: for (int k = 0; k < 3; k++) v[9+k] = v[3+k];     // c on a
            6: for (int k = 0; k < 3; k++) v[6+k] = v[9+k];     // b on c
            default: ;
        endcase
        return pack(v);
    endfunction

    // Input driver
    initial begin
        t_weights zero_res;
        t_weights unit_res;
        logic [bcc_pkg::IN_W-1:0] item;
        int total;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_rst_n       <= 1'b0;
        quiet = 1'b0;
        n_sent = 0;
        zero_res = '0;
        zero_res.degen = 1'b1;
        unit_res = '0;

        // All zero, all max and all min: degenerate
        add_row('{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1'b1, zero_res);
        add_row('{32767,32767,32767, 32767,32767,32767, 32767,32767,32767,
                  32767,32767,32767}, 1'b1, zero_res);
        add_row('{-32768,-32768,-32768, -32768,-32768,-32768, -32768,-32768,-32768,
                  -32768,-32768,-32768}, 1'b1, zero_res);
        // Collinear vertices: degenerate
        add_row('{100,-5,7, 0,0,0, 256,256,256, 512,512,512}, 1'b1, zero_res);
        // Point on each vertex of a unit right triangle
        unit_res.alpha = 32'h0001_0000;
        add_row('{0,0,0, 0,0,0, 256,0,0, 0,256,0}, 1'b1, unit_res);
        unit_res = '0;
        unit_res.beta = 32'h0001_0000;
        add_row('{256,0,0, 0,0,0, 256,0,0, 0,256,0}, 1'b1, unit_res);
        unit_res = '0;
        unit_res.gamma = 32'h0001_0000;
        add_row('{0,256,0, 0,0,0, 256,0,0, 0,256,0}, 1'b1, unit_res);
        // Tiny triangle with far point: saturation both ways
        add_row('{-32768,-32768,0, 0,0,0, 1,0,0, 0,1,0}, 1'b0, zero_res);
        add_row('{32767,32767,32767, 0,0,0, 0,1,0, 1,0,0}, 1'b0, zero_res);
        add_row('{-32768,32767,-32768, 0,0,0, 0,0,1, 0,1,0}, 1'b0, zero_res);
        // Extreme spans and mixed extremes
        add_row('{0,0,0, -32768,-32768,-32768, 32767,-32768,-32768,
                  -32768,32767,32767}, 1'b0, zero_res);
        add_row('{32767,-32768,32767, -32768,32767,-32768, 32767,32767,-32768,
                  32767,-32768,32767}, 1'b0, zero_res);
        add_row('{1,-1,1, -32768,0,32767, 32767,-32768,0, 0,32767,-32768},
                1'b0, zero_res);
        // Off-plane point, centroid-ish point
        add_row('{85,85,300, 0,0,0, 256,0,0, 0,256,0}, 1'b0, zero_res);
        add_row('{-1,-1,-1, 1,2,3, -300,40,9, 77,-900,12}, 1'b0, zero_res);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        total = rows.size() + N_RANDOM;
        for (int i = 0; i < total; i++) begin
            if (i >= total - QUIET_TAIL) quiet = 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            item = (i < rows.size()) ? rows[i].coords : random_item();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= item;
            do @(posedge i_clk); while (!s_axis_tready);
            if (i < rows.size() && rows[i].typed) pending_weights.push_back(rows[i].res);
            else pending_weights.push_back(barycentric(item));
            n_sent++;
        end
        s_axis_tvalid <= 1'b0;

        while (pending_weights.size() != 0) @(posedge i_clk);
        repeat (bcc_pkg::TOTAL_LAT + 10) @(posedge i_clk);
        $display("Sent %0d items (%0d directed); %0d results checked, %0d degenerate,",
                 n_sent, rows.size(), n_results, n_degen);
        $display("%0d with a saturated weight; input stalled by a long output hold-off.",
                 n_sat);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Output side: random hold-off bursts, one long stall to fill the pipeline
    int  hold_left;
    bit  long_done;
    initial begin
        m_axis_tready <= 1'b0;
        hold_left = 0;
        long_done = 1'b0;
    end

    always @(posedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (!long_done && n_sent >= 300) begin
            long_done = 1'b1;
            hold_left = 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= (hold_left == 0);
        end else if ($urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 16);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_weights want;
        t_weights got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata, m_axis_tuser};
            if (pending_weights.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result item %h", got);
            end else begin
                want = pending_weights.pop_front();
                n_results++;
                if (want.degen) n_degen++;
                if (want.alpha inside {bcc_pkg::W_MAX, bcc_pkg::W_MIN}
                    || want.beta inside {bcc_pkg::W_MAX, bcc_pkg::W_MIN}
                    || want.gamma inside {bcc_pkg::W_MAX, bcc_pkg::W_MIN}) n_sat++;
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch at result %0d: alpha %h/%h beta %h/%h ",
                                  "gamma %h/%h degen %b/%b (exp/got)"},
                                 n_results, want.alpha, got.alpha, want.beta, got.beta,
                                 want.gamma, got.gamma, want.degen, got.degen);
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout with %0d results outstanding", pending_weights.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

@@ files.f @@
design/bcc_pkg.sv
design/bcc_geom.sv
design/bcc_div.sv
design/triangle_barycentric_coordinates.sv
sim/testbench.sv
